>>> hw/rtl/ultrasonic_range_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// ultrasonic range controller assertion macros
// shared property wrappers, clocked on clk_i and quiet while in reset
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_CONTROLLER_UNIT_MACROS_SVH
`define ULTRASONIC_RANGE_CONTROLLER_UNIT_MACROS_SVH

// property must hold at every edge out of reset
`define URC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define URC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> hw/rtl/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg
// types and constants of the ultrasonic range controller
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int unsigned EchoUsBits = 16;
  localparam int unsigned CmDivisor  = 58;
  localparam int unsigned QueueDepth = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_CYCLES_PER_US = 3'd0;
  localparam logic [2:0] CFG_SETTLE_US     = 3'd1;
  localparam logic [2:0] CFG_TRIGGER_US    = 3'd2;
  localparam logic [2:0] CFG_GAP_US        = 3'd3;

  // external phase codes
  localparam logic [2:0] PH_SETTLE  = 3'd0;
  localparam logic [2:0] PH_TRIGGER = 3'd1;
  localparam logic [2:0] PH_WAIT    = 3'd2;
  localparam logic [2:0] PH_MEASURE = 3'd3;
  localparam logic [2:0] PH_GAP     = 3'd4;

  typedef enum logic [4:0] {
    ST_SETTLE  = 5'b00001,
    ST_TRIGGER = 5'b00010,
    ST_WAIT    = 5'b00100,
    ST_MEASURE = 5'b01000,
    ST_GAP     = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [9:0]  cycles_per_us;
    logic [7:0]  settle_us;
    logic [7:0]  trigger_us;
    logic [19:0] gap_us;
  } cfg_t;

  // head of the sample queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic echo;
  } q_head_t;

endpackage

>>> hw/rtl/urc_front.sv
// ----------------------------------------------------------------------------
// urc_front
// accepts echo samples and holds them in a short queue for the sequencer
// ----------------------------------------------------------------------------
module urc_front
  import urc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    echo_i,
  output q_head_t head_o,
  input  logic    pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [QueueDepth-1:0] mem_q;
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  push;

  assign in_stall_o = (count_q == CntW'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;

  assign head_o.valid = (count_q != '0);
  assign head_o.echo  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    priority if (push && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= echo_i;
    end
  end

endmodule

>>> hw/rtl/urc_back.sv
// ----------------------------------------------------------------------------
// urc_back
// phase sequencer, microsecond prescaler, echo timer and result register
// ----------------------------------------------------------------------------
module urc_back
  import urc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  q_head_t     head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trigger_o,
  output logic        distance_valid_o,
  output logic [10:0] range_cm_o,
  output logic [2:0]  phase_o
);

  // floor(x / 58) as a multiply by a rounded-up reciprocal, exact for all counts
  localparam int unsigned DivShift = EchoUsBits + 6;
  localparam longint unsigned DivMulL =
    ((64'd1 << DivShift) + 64'(CmDivisor) - 64'd1) / 64'(CmDivisor);
  localparam int unsigned ProdW = 2 * EchoUsBits + 1;
  localparam int unsigned QuotW = ProdW - DivShift;
  localparam logic [EchoUsBits:0] DivMul = DivMulL[EchoUsBits:0];

  phase_e                phase_q, phase_d;
  logic [9:0]            presc_q, presc_d;
  logic [19:0]           us_cnt_q, us_cnt_d;
  logic [EchoUsBits-1:0] echo_cnt_q, echo_cnt_d;
  logic [10:0]           dist_q, dist_d;

  logic                  out_valid_q;
  logic                  trig_q, dval_q;
  logic [2:0]            ph_out_q;

  logic                  step;
  logic [9:0]            lim;
  logic                  tick;
  logic [9:0]            presc_inc;
  logic [19:0]           us_inc;
  logic [19:0]           target;
  logic                  timed_done;
  logic [ProdW-1:0]      prod;
  logic [QuotW-1:0]      quot;
  logic [10:0]           quot_sat;
  logic                  valid_now;
  logic [2:0]            ph_code;

  assign step  = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = step;

  // microsecond tick, a zero setting counts as one
  assign lim       = (cfg_i.cycles_per_us == '0) ? 10'd1 : cfg_i.cycles_per_us;
  assign tick      = ({1'b0, presc_q} + 11'd1) >= {1'b0, lim};
  assign presc_inc = tick ? 10'd0 : presc_q + 10'd1;

  assign us_inc = (tick && us_cnt_q != 20'hFFFFF) ? us_cnt_q + 20'd1 : us_cnt_q;

  always_comb begin
    unique case (phase_q)
      ST_SETTLE:  target = {12'd0, cfg_i.settle_us};
      ST_TRIGGER: target = {12'd0, cfg_i.trigger_us};
      default:    target = cfg_i.gap_us;
    endcase
  end
  assign timed_done = (us_inc >= target);

  assign prod     = ProdW'(echo_cnt_q) * ProdW'(DivMul);
  assign quot     = prod[ProdW-1:DivShift];
  assign quot_sat = (quot > QuotW'(2047)) ? 11'h7FF : 11'(quot);

  always_comb begin
    phase_d    = phase_q;
    presc_d    = presc_q;
    us_cnt_d   = us_cnt_q;
    echo_cnt_d = echo_cnt_q;
    dist_d     = dist_q;
    valid_now  = 1'b0;
    ph_code    = PH_SETTLE;
    unique case (phase_q)
      ST_SETTLE, ST_TRIGGER, ST_GAP: begin
        ph_code = (phase_q == ST_SETTLE)  ? PH_SETTLE :
                  (phase_q == ST_TRIGGER) ? PH_TRIGGER : PH_GAP;
        if (timed_done) begin
          phase_d  = (phase_q == ST_SETTLE)  ? ST_TRIGGER :
                     (phase_q == ST_TRIGGER) ? ST_WAIT : ST_SETTLE;
          presc_d  = '0;
          us_cnt_d = '0;
        end else begin
          presc_d  = presc_inc;
          us_cnt_d = us_inc;
        end
      end
      ST_WAIT: begin
        ph_code = PH_WAIT;
        if (head_i.echo) begin
          phase_d    = ST_MEASURE;
          presc_d    = '0;
          us_cnt_d   = '0;
          echo_cnt_d = '0;
        end
      end
      ST_MEASURE: begin
        ph_code = PH_MEASURE;
        if (head_i.echo) begin
          presc_d = presc_inc;
          if (tick && echo_cnt_q != '1) begin
            echo_cnt_d = echo_cnt_q + EchoUsBits'(1);
          end
        end else begin
          dist_d    = quot_sat;
          valid_now = 1'b1;
          phase_d   = ST_GAP;
          presc_d   = '0;
          us_cnt_d  = '0;
        end
      end
      default: begin
        phase_d    = ST_SETTLE;
        presc_d    = '0;
        us_cnt_d   = '0;
        echo_cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ST_SETTLE;
      presc_q     <= '0;
      us_cnt_q    <= '0;
      echo_cnt_q  <= '0;
      dist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q    <= phase_d;
        presc_q    <= presc_d;
        us_cnt_q   <= us_cnt_d;
        echo_cnt_q <= echo_cnt_d;
        dist_q     <= dist_d;
      end
      out_valid_q <= step || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      trig_q   <= (phase_q == ST_TRIGGER);
      dval_q   <= valid_now;
      ph_out_q <= ph_code;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign trigger_o        = trig_q;
  assign distance_valid_o = dval_q;
  assign range_cm_o       = dist_q;
  assign phase_o          = ph_out_q;

endmodule

>>> hw/rtl/ultrasonic_range_controller_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_controller_unit
// echo timer for an ultrasonic ranging sensor: trigger drive and distance
// ----------------------------------------------------------------------------
// channel  direction  handshake                payload
// in       input      in_valid_i / in_stall_o  echo_i
// out      output     out_valid_o/out_stall_i  trigger_o, distance_valid_o,
//                                              range_cm_o, phase_o
// cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// one echo sample in, one result out per clock unless the output stalls; a
// result is offered once its sample has passed the queue entry and then the
// sequencer step into the output register.
// reset clears queue, sequencer, counters and loads the register defaults.
// an output stall holds the result; the queue takes samples until it is full and
// then stalls the input, which resumes once the sequencer pops the queue again.
// ----------------------------------------------------------------------------
`include "ultrasonic_range_controller_unit_macros.svh"

module ultrasonic_range_controller_unit
  import urc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        echo_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trigger_o,
  output logic        distance_valid_o,
  output logic [10:0] range_cm_o,
  output logic [2:0]  phase_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  cfg_t    cfg_q;
  q_head_t head;
  logic    pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycles_per_us <= 10'd64;
      cfg_q.settle_us     <= 8'd2;
      cfg_q.trigger_us    <= 8'd10;
      cfg_q.gap_us        <= 20'd100000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CYCLES_PER_US: cfg_q.cycles_per_us <= cfg_data_i[9:0];
        CFG_SETTLE_US:     cfg_q.settle_us     <= cfg_data_i[7:0];
        CFG_TRIGGER_US:    cfg_q.trigger_us    <= cfg_data_i[7:0];
        CFG_GAP_US:        cfg_q.gap_us        <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  urc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .echo_i     (echo_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  urc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .trigger_o        (trigger_o),
    .distance_valid_o (distance_valid_o),
    .range_cm_o       (range_cm_o),
    .phase_o          (phase_o)
  );

  `URC_ASSERT(a_dval_phase, out_valid_o && distance_valid_o |-> phase_o == PH_MEASURE, "bad flag")
  `URC_ASSERT(a_trig_phase, out_valid_o |-> trigger_o == (phase_o == PH_TRIGGER), "bad trigger")
  `URC_ASSERT_NEVER(a_pop_empty, pop && !head.valid, "sequencer stepped on an empty queue")
  `URC_ASSERT(a_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(phase_o), "lost item")

endmodule

>>> verif/ultrasonic_range_controller_unit_test.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_controller_unit_test
// feeds echo samples and register writes into the range controller, keeps a
// sample-by-sample shadow of its sequencer and checks every result in order
// ----------------------------------------------------------------------------
module ultrasonic_range_controller_unit_test;
  import urc_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        echo_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        trigger_o;
  logic        distance_valid_o;
  logic [10:0] range_cm_o;
  logic [2:0]  phase_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [19:0] cfg_data_i;

  typedef struct packed {
    logic        trigger;
    logic        dvalid;
    logic [10:0] range_cm;
    logic [2:0]  phase;
  } range_result_t;

  // register shadows
  logic [9:0]  cpu_r;
  logic [7:0]  settle_r;
  logic [7:0]  trig_r;
  logic [19:0] gap_r;

  // sequencer shadow
  logic [2:0]            phase_q;
  logic [9:0]            prescale_q;
  logic [19:0]           phase_us_q;
  logic [EchoUsBits-1:0] echo_us_q;
  logic [10:0]           dist_q;

  range_result_t pending_results[$];
  int unsigned   fail_count;
  int unsigned   items_sent;
  int unsigned   quiet_cycles;
  bit            idling;

  ultrasonic_range_controller_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .echo_i           (echo_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .trigger_o        (trigger_o),
    .distance_valid_o (distance_valid_o),
    .range_cm_o       (range_cm_o),
    .phase_o          (phase_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- shadow

  function automatic void reset_shadow();
    cpu_r      = 10'd64;
    settle_r   = 8'd2;
    trig_r     = 8'd10;
    gap_r      = 20'd100000;
    phase_q    = PH_SETTLE;
    prescale_q = '0;
    phase_us_q = '0;
    echo_us_q  = '0;
    dist_q     = '0;
  endfunction

  function automatic void go_phase(logic [2:0] nxt);
    phase_q    = nxt;
    prescale_q = '0;
    phase_us_q = '0;
  endfunction

  // a zero prescale ticks on every sample, like a prescale of one
  function automatic bit us_tick();
    int unsigned lim;
    lim = (cpu_r == '0) ? 1 : cpu_r;
    if (prescale_q + 32'd1 >= lim) begin
      prescale_q = '0;
      return 1'b1;
    end
    prescale_q = prescale_q + 10'd1;
    return 1'b0;
  endfunction

  function automatic void timed_phase(int unsigned target, logic [2:0] nxt);
    if (us_tick() && phase_us_q != 20'hFFFFF) phase_us_q = phase_us_q + 20'd1;
    if (phase_us_q >= target) go_phase(nxt);
  endfunction

  function automatic range_result_t predict_sample(logic level);
    range_result_t r;
    logic [2:0]    cur;
    int unsigned   quot;
    cur = phase_q;
    r.dvalid = 1'b0;
    case (cur)
      PH_SETTLE:  timed_phase(32'(settle_r), PH_TRIGGER);
      PH_TRIGGER: timed_phase(32'(trig_r), PH_WAIT);
      PH_WAIT: begin
        if (level) begin
          go_phase(PH_MEASURE);
          echo_us_q = '0;
        end
      end
      PH_MEASURE: begin
        if (level) begin
          // echo count saturates
          if (us_tick() && echo_us_q != '1) echo_us_q = echo_us_q + EchoUsBits'(1);
        end else begin
          quot     = echo_us_q / CmDivisor;
          dist_q   = (quot > 2047) ? 11'd2047 : quot[10:0];
          r.dvalid = 1'b1;
          go_phase(PH_GAP);
        end
      end
      PH_GAP:     timed_phase(gap_r, PH_SETTLE);
      default: begin
        go_phase(PH_SETTLE);
        echo_us_q = '0;
      end
    endcase
    r.trigger  = (cur == PH_TRIGGER);
    r.range_cm = dist_q;
    r.phase    = cur;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_echo(logic level);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    echo_i     <= level;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_sample(level));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // let the queue and output register empty, plus margin
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] index, logic [19:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_CYCLES_PER_US: cpu_r    = value[9:0];
      CFG_SETTLE_US:     settle_r = value[7:0];
      CFG_TRIGGER_US:    trig_r   = value[7:0];
      CFG_GAP_US:        gap_r    = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // unused upper data bits are filled with noise
  task automatic configure(logic [9:0] cpu, logic [7:0] settle, logic [7:0] trig,
                           logic [19:0] gap);
    drain_results();
    write_reg(CFG_CYCLES_PER_US, {10'($urandom), cpu});
    write_reg(CFG_SETTLE_US, {12'($urandom), settle});
    write_reg(CFG_TRIGGER_US, {12'($urandom), trig});
    write_reg(CFG_GAP_US, gap);
    cfg_valid_i <= 1'b0;
  endtask

  // one ranging round: noise until wait phase, a delay, an echo pulse, optionally the gap
  task automatic run_round(int unsigned wait_len, int unsigned high_len, bit finish_gap);
    while (phase_q != PH_WAIT) send_echo(1'($urandom_range(0, 1)));
    repeat (wait_len) send_echo(1'b0);
    repeat (high_len) send_echo(1'b1);
    send_echo(1'b0);
    while (finish_gap && phase_q == PH_GAP) send_echo(1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s after %0d items: got %0d, expected %0d",
             what, items_sent, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    range_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (trigger_o !== want.trigger) report_mismatch("trigger", trigger_o, want.trigger);
        if (distance_valid_o !== want.dvalid)
          report_mismatch("distance_valid", distance_valid_o, want.dvalid);
        if (range_cm_o !== want.range_cm) report_mismatch("range_cm", range_cm_o, want.range_cm);
        if (phase_o !== want.phase) report_mismatch("phase", phase_o, want.phase);
      end
    end
  end

  // output stall in random bursts
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (idling && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("no handshake for %0d cycles", QuietLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    // default prescale of 64: settle runs out into trigger
    repeat (135) send_echo(1'($urandom_range(0, 1)));
  endtask

  task automatic test_bad_index();
    configure(10'd1, 8'd0, 8'd1, 20'd1);
    for (int i = CFG_GAP_US + 1; i < 8; i++) write_reg(3'(i), '1);
    cfg_valid_i <= 1'b0;
    // two echo pulses, both just under one centimetre
    run_round(2, 57, 1);
    run_round(0, 58, 1);
  endtask

  task automatic test_zero_timing();
    configure(10'd0, 8'd0, 8'd0, 20'd0);
    run_round(0, 3, 1);
    run_round(1, 20, 1);
  endtask

  task automatic test_wide_prescale();
    configure(10'd1023, 8'd0, 8'd0, 20'd0);
    run_round(0, 30, 1);
  endtask

  task automatic test_missing_echo();
    configure(10'd1, 8'd1, 8'd1, 20'd1);
    run_round(40, 10, 1);
  endtask

  task automatic test_gap_shortened();
    configure(10'd1, 8'd1, 8'd1, 20'hFFFFF);
    run_round(1, 10, 0);
    repeat (20) send_echo(1'($urandom_range(0, 1)));
    // count already past the new gap, so it ends on the next tick
    configure(10'd1, 8'd1, 8'd1, 20'd3);
    while (phase_q == PH_GAP) send_echo(1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_rounds();
    int unsigned rounds;
    int unsigned first;
    int unsigned high;
    rounds = 0;
    first  = items_sent;
    while (items_sent - first < 100) begin
      if (rounds % 2 == 0)
        configure(10'($urandom_range(0, 2)), 8'($urandom_range(0, 4)),
                  8'($urandom_range(0, 4)), 20'($urandom_range(0, 5)));
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(10, 30)) send_echo(1'($urandom_range(0, 1)));
        1: run_round($urandom_range(0, 3), $urandom_range(1, 3), 1);
        default: begin
          if ($urandom_range(0, 4) == 0)
            high = 58 * ((cpu_r == '0) ? 1 : cpu_r) + $urandom_range(0, 57);
          else
            high = $urandom_range(1, 20);
          run_round($urandom_range(0, 6), high, 1);
        end
      endcase
      rounds++;
    end
  endtask

  task automatic test_steady_flow();
    idling = 1'b0;
    configure(10'd2, 8'd3, 8'd2, 20'd4);
    repeat (2) run_round($urandom_range(0, 4), $urandom_range(10, 30), 1);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    echo_i      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    fail_count  = 0;
    items_sent  = 0;
    idling      = 1'b1;
    reset_shadow();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_bad_index();
    test_zero_timing();
    test_wide_prescale();
    test_missing_echo();
    test_gap_shortened();
    test_random_rounds();
    test_steady_flow();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("items never delivered", 0, pending_results.size());
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> ultrasonic_range_controller_unit.f
+incdir+hw/rtl
hw/rtl/urc_pkg.sv
hw/rtl/urc_front.sv
hw/rtl/urc_back.sv
hw/rtl/ultrasonic_range_controller_unit.sv
verif/ultrasonic_range_controller_unit_test.sv
